### sv/mac_pkg.sv
// Shared package for the moving-average crossover trader.
// Holds widths, codes, stage payload structs and the window clamp function.
// No dependencies; every other file refers to it by scoped names.
package mac_pkg;

  // Ring depth. It must be a power of two because ring indexes wrap by truncation.
  localparam int MAX_WINDOW = 256;
  localparam int PRICE_BITS = 32;

  localparam int AW        = $clog2(MAX_WINDOW);
  localparam int CNT_W     = $clog2(MAX_WINDOW + 1);
  localparam int WIN_W     = 9;
  localparam int EXT_W     = (WIN_W > CNT_W) ? WIN_W : CNT_W;
  localparam int SIZE_W    = 16;
  localparam int SUM_W     = PRICE_BITS + AW;
  localparam int PROD_W    = SUM_W + CNT_W;
  localparam int DIFF_W    = PRICE_BITS + 1;
  localparam int PROFIT_W  = DIFF_W + SIZE_W + 1;
  localparam int ADD_W     = PROFIT_W + 1;
  localparam int PNL_W     = 48;
  localparam int DD_W      = 47;
  localparam int DDX_W     = PNL_W + 1;
  localparam int CNT_OUT_W = 32;
  localparam int TP_W      = 32;
  localparam int ACT_W     = 3;

  localparam int IN_DATA_W  = 32;
  localparam int OUT_BITS   = TP_W + PNL_W + DD_W + 2 * CNT_OUT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SIZE  = 2'd2;

  localparam logic [WIN_W-1:0]  SHORT_RESET = 9'd20;
  localparam logic [WIN_W-1:0]  LONG_RESET  = 9'd50;
  localparam logic [SIZE_W-1:0] SIZE_RESET  = 16'd1;

  localparam logic [PNL_W-1:0] PNL_MAX = {1'b0, {(PNL_W-1){1'b1}}};
  localparam logic [PNL_W-1:0] PNL_MIN = {1'b1, {(PNL_W-1){1'b0}}};

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE      = 3'd0,
    ACT_BUY       = 3'd1,
    ACT_SELL      = 3'd2,
    ACT_FORCE     = 3'd3,
    ACT_BUY_FORCE = 3'd4
  } act_t;

  typedef struct packed {
    logic [CNT_W-1:0] l;
    logic [CNT_W-1:0] s;
  } win_t;

  // Item leaving the ring stage: new price, the two prices that drop out of
  // the windows and the fill-level flags.
  typedef struct packed {
    logic [PRICE_BITS-1:0] price;
    logic                  last;
    logic [PRICE_BITS-1:0] old_s;
    logic [PRICE_BITS-1:0] old_l;
    logic                  use_s;
    logic                  use_l;
    logic                  rel_ok;
  } s1_t;

  // Trade decision for one item.
  typedef struct packed {
    act_t                     action;
    logic [PRICE_BITS-1:0]    price;
    logic                     close;
    logic                     win;
    logic signed [DIFF_W-1:0] diff;
  } dec_t;

  typedef struct packed {
    act_t                    action;
    logic [TP_W-1:0]         tprice;
    logic signed [PNL_W-1:0] pnl;
    logic [DD_W-1:0]         max_dd;
    logic [CNT_OUT_W-1:0]    trades;
    logic [CNT_OUT_W-1:0]    wins;
  } res_t;

  // Zero acts as one, long is capped at the ring depth, short at long.
  function automatic win_t eff_windows(input logic [WIN_W-1:0] short_reg,
                                       input logic [WIN_W-1:0] long_reg);
    logic [EXT_W-1:0] l_x;
    logic [EXT_W-1:0] s_x;
    win_t             w;
    l_x = EXT_W'(long_reg);
    if (l_x == '0) l_x = EXT_W'(1);
    if (l_x > EXT_W'(MAX_WINDOW)) l_x = EXT_W'(MAX_WINDOW);
    s_x = EXT_W'(short_reg);
    if (s_x == '0) s_x = EXT_W'(1);
    if (s_x > l_x) s_x = l_x;
    w.l = CNT_W'(l_x);
    w.s = CNT_W'(s_x);
    return w;
  endfunction

endpackage

### sv/mac_front.sv
// Input stage: price ring memory, write slot and fill counter.
// Writes each accepted price and reads the two prices leaving the windows.
// Depends on mac_pkg.
module mac_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          series_clr,
  input  mac_pkg::win_t                 win,
  input  logic                          in_valid,
  input  logic [mac_pkg::IN_DATA_W-1:0] in_price,
  input  logic                          in_last,
  output logic                          in_ready,
  output logic                          s1_valid,
  output mac_pkg::s1_t                  s1,
  input  logic                          s1_ready
);

  logic [mac_pkg::PRICE_BITS-1:0] ring [mac_pkg::MAX_WINDOW];

  logic                      v1_r, v1_nxt;
  logic [mac_pkg::AW-1:0]    ws_r, ws_nxt;
  logic [mac_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  mac_pkg::s1_t              s1_r;

  logic                           accept;
  logic [mac_pkg::PRICE_BITS-1:0] price_p;
  logic [mac_pkg::AW-1:0]         rd_s_addr, rd_l_addr;
  logic                           use_s, use_l, rel_ok;

  assign in_ready  = !v1_r || s1_ready;
  assign accept    = in_valid && in_ready;
  assign price_p   = mac_pkg::PRICE_BITS'(in_price);
  assign rd_s_addr = ws_r - win.s[mac_pkg::AW-1:0];
  assign rd_l_addr = ws_r - win.l[mac_pkg::AW-1:0];

  assign use_s  = cnt_r >= win.s;
  assign use_l  = cnt_r >= win.l;
  assign rel_ok = ({1'b0, cnt_r} + {{mac_pkg::CNT_W{1'b0}}, 1'b1}) >= {1'b0, win.l};

  always_comb begin
    v1_nxt  = accept || (v1_r && !s1_ready);
    ws_nxt  = ws_r;
    cnt_nxt = cnt_r;
    if (series_clr) begin
      ws_nxt  = '0;
      cnt_nxt = '0;
    end else if (accept) begin
      if (in_last) begin
        ws_nxt  = '0;
        cnt_nxt = '0;
      end else begin
        ws_nxt = ws_r + 1'b1;
        if (cnt_r != mac_pkg::CNT_W'(mac_pkg::MAX_WINDOW)) cnt_nxt = cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r  <= 1'b0;
      ws_r  <= '0;
      cnt_r <= '0;
    end else begin
      v1_r  <= v1_nxt;
      ws_r  <= ws_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Reads return the old contents when a window spans the whole ring.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[ws_r]  <= price_p;
      s1_r.old_s  <= ring[rd_s_addr];
      s1_r.old_l  <= ring[rd_l_addr];
      s1_r.price  <= price_p;
      s1_r.last   <= in_last;
      s1_r.use_s  <= use_s;
      s1_r.use_l  <= use_l;
      s1_r.rel_ok <= rel_ok;
    end
  end

  assign s1_valid = v1_r;
  assign s1       = s1_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= mac_pkg::CNT_W'(mac_pkg::MAX_WINDOW))
    else $error("fill counter above ring depth");

  a_slot_track: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < mac_pkg::CNT_W'(mac_pkg::MAX_WINDOW) |-> ws_r == cnt_r[mac_pkg::AW-1:0])
    else $error("write slot out of step with fill counter");

endmodule

### sv/mac_signal.sv
// Signal stages: running window sums, cross-multiplied averages and the
// buy/sell decision with position state. Depends on mac_pkg.
module mac_signal (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          series_clr,
  input  mac_pkg::win_t win,
  input  logic          s1_valid,
  input  mac_pkg::s1_t  s1,
  output logic          s1_ready,
  output logic          d_valid,
  output mac_pkg::dec_t d,
  input  logic          d_ready
);

  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_t;

  // Sum stage.
  logic                           v2_r, v2_nxt;
  logic [mac_pkg::SUM_W-1:0]      acc_s_r, acc_s_nxt, acc_l_r, acc_l_nxt;
  logic [mac_pkg::SUM_W-1:0]      ss_r, ls_r, sum_s, sum_l;
  logic [mac_pkg::PRICE_BITS-1:0] price2_r;
  logic                           last2_r, dec2_r, rel2_r;

  // Product stage.
  logic                           v3_r, v3_nxt;
  logic [mac_pkg::PROD_W-1:0]     a_r, b_r;
  logic [mac_pkg::PRICE_BITS-1:0] price3_r;
  logic                           last3_r, dec3_r, rel3_r;

  // Decision stage.
  logic                           v4_r, v4_nxt;
  mac_pkg::dec_t                  d_r, d_nxt;
  logic                           holding_r, holding_nxt;
  logic [mac_pkg::PRICE_BITS-1:0] entry_r, entry_nxt, entry_use;
  rel_t                           prev_r, prev_nxt, rel;
  logic                           buy, xsell, held, force_cl;

  logic rdy2, rdy3, rdy4, load2, load3, load4;

  assign rdy4     = !v4_r || d_ready;
  assign rdy3     = !v3_r || rdy4;
  assign rdy2     = !v2_r || rdy3;
  assign s1_ready = rdy2;
  assign load2    = s1_valid && rdy2;
  assign load3    = v2_r && rdy3;
  assign load4    = v3_r && rdy4;

  assign v2_nxt = load2 || (v2_r && !rdy3);
  assign v3_nxt = load3 || (v3_r && !rdy4);
  assign v4_nxt = load4 || (v4_r && !d_ready);

  // Oldest sample leaves, newest enters; the final value is never negative
  // so wrapping arithmetic is exact.
  assign sum_s = acc_s_r - (s1.use_s ? mac_pkg::SUM_W'(s1.old_s) : '0)
                 + mac_pkg::SUM_W'(s1.price);
  assign sum_l = acc_l_r - (s1.use_l ? mac_pkg::SUM_W'(s1.old_l) : '0)
                 + mac_pkg::SUM_W'(s1.price);

  always_comb begin
    acc_s_nxt = acc_s_r;
    acc_l_nxt = acc_l_r;
    if (series_clr) begin
      acc_s_nxt = '0;
      acc_l_nxt = '0;
    end else if (load2) begin
      acc_s_nxt = s1.last ? '0 : sum_s;
      acc_l_nxt = s1.last ? '0 : sum_l;
    end
  end

  always_comb begin
    rel = (a_r > b_r) ? REL_GREATER : ((a_r < b_r) ? REL_LESS : REL_EQUAL);
    buy   = 1'b0;
    xsell = 1'b0;
    if (rel3_r && dec3_r) begin
      if (!holding_r) buy = (prev_r != REL_GREATER) && (rel == REL_GREATER);
      else            xsell = (prev_r != REL_LESS) && (rel == REL_LESS);
    end
    held      = (holding_r || buy) && !xsell;
    force_cl  = last3_r && held;
    entry_use = buy ? price3_r : entry_r;

    if (force_cl)   d_nxt.action = buy ? mac_pkg::ACT_BUY_FORCE : mac_pkg::ACT_FORCE;
    else if (buy)   d_nxt.action = mac_pkg::ACT_BUY;
    else if (xsell) d_nxt.action = mac_pkg::ACT_SELL;
    else            d_nxt.action = mac_pkg::ACT_NONE;

    d_nxt.price = (buy || xsell || force_cl) ? price3_r : '0;
    d_nxt.close = xsell || force_cl;
    d_nxt.win   = price3_r > entry_use;
    d_nxt.diff  = {1'b0, price3_r} - {1'b0, entry_use};

    holding_nxt = holding_r;
    entry_nxt   = entry_r;
    prev_nxt    = prev_r;
    if (load4) begin
      holding_nxt = held && !last3_r;
      if (buy) entry_nxt = price3_r;
      if (last3_r)     prev_nxt = REL_EQUAL;
      else if (rel3_r) prev_nxt = rel;
    end
    if (series_clr) prev_nxt = REL_EQUAL;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r      <= 1'b0;
      v3_r      <= 1'b0;
      v4_r      <= 1'b0;
      acc_s_r   <= '0;
      acc_l_r   <= '0;
      holding_r <= 1'b0;
      entry_r   <= '0;
      prev_r    <= REL_EQUAL;
    end else begin
      v2_r      <= v2_nxt;
      v3_r      <= v3_nxt;
      v4_r      <= v4_nxt;
      acc_s_r   <= acc_s_nxt;
      acc_l_r   <= acc_l_nxt;
      holding_r <= holding_nxt;
      entry_r   <= entry_nxt;
      prev_r    <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      ss_r     <= sum_s;
      ls_r     <= sum_l;
      price2_r <= s1.price;
      last2_r  <= s1.last;
      dec2_r   <= s1.use_l;
      rel2_r   <= s1.rel_ok;
    end
    if (load3) begin
      a_r      <= ss_r * win.l;
      b_r      <= ls_r * win.s;
      price3_r <= price2_r;
      last3_r  <= last2_r;
      dec3_r   <= dec2_r;
      rel3_r   <= rel2_r;
    end
    if (load4) d_r <= d_nxt;
  end

  assign d_valid = v4_r;
  assign d       = d_r;

  a_buy_holds: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && d_r.action == mac_pkg::ACT_BUY |-> holding_r)
    else $error("buy shown while flat");

  a_sell_flat: assert property (@(posedge clk) disable iff (!rst_n)
    v4_r && (d_r.action == mac_pkg::ACT_SELL || d_r.action == mac_pkg::ACT_FORCE ||
             d_r.action == mac_pkg::ACT_BUY_FORCE) |-> !holding_r)
    else $error("sell shown while position open");

endmodule

### sv/mac_acct.sv
// Accounting stages: trade profit, saturating PnL, trade counters, peak,
// drawdown and the result register. Depends on mac_pkg.
module mac_acct (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [mac_pkg::SIZE_W-1:0] size,
  input  logic                       d_valid,
  input  mac_pkg::dec_t              d,
  output logic                       d_ready,
  output logic                       out_valid,
  output mac_pkg::res_t              res,
  input  logic                       out_ready
);

  // Profit stage.
  logic                             v5_r, v5_nxt;
  mac_pkg::act_t                    act5_r;
  logic [mac_pkg::PRICE_BITS-1:0]   tp5_r;
  logic                             close5_r, win5_r;
  logic signed [mac_pkg::PROFIT_W-1:0] profit5_r, profit_nxt;

  // PnL stage.
  logic                             v6_r, v6_nxt;
  mac_pkg::act_t                    act6_r;
  logic [mac_pkg::PRICE_BITS-1:0]   tp6_r;
  logic signed [mac_pkg::PNL_W-1:0] pnl_r, pnl_nxt;
  logic signed [mac_pkg::ADD_W-1:0] pnl_sum;
  logic [mac_pkg::ADD_W-mac_pkg::PNL_W:0] pnl_hi;
  logic [mac_pkg::CNT_OUT_W-1:0]    trades_r, trades_nxt, wins_r, wins_nxt;

  // Peak stage.
  logic                             v7_r, v7_nxt;
  mac_pkg::act_t                    act7_r;
  logic [mac_pkg::PRICE_BITS-1:0]   tp7_r;
  logic signed [mac_pkg::PNL_W-1:0] pnl7_r, peak_r, peak_nxt;
  logic signed [mac_pkg::DDX_W-1:0] dd_raw;
  logic [mac_pkg::DD_W-1:0]         dd_nxt, dd7_r;
  logic [mac_pkg::CNT_OUT_W-1:0]    trades7_r, wins7_r;
  logic                             new_peak;

  // Result register.
  logic                             v8_r, v8_nxt;
  mac_pkg::act_t                    act8_r;
  logic [mac_pkg::PRICE_BITS-1:0]   tp8_r;
  logic signed [mac_pkg::PNL_W-1:0] pnl8_r;
  logic [mac_pkg::DD_W-1:0]         worst_r, worst_nxt;
  logic [mac_pkg::CNT_OUT_W-1:0]    trades8_r, wins8_r;

  logic rdy5, rdy6, rdy7, rdy8, load5, load6, load7, load8;

  assign rdy8    = !v8_r || out_ready;
  assign rdy7    = !v7_r || rdy8;
  assign rdy6    = !v6_r || rdy7;
  assign rdy5    = !v5_r || rdy6;
  assign d_ready = rdy5;
  assign load5   = d_valid && rdy5;
  assign load6   = v5_r && rdy6;
  assign load7   = v6_r && rdy7;
  assign load8   = v7_r && rdy8;

  assign v5_nxt = load5 || (v5_r && !rdy6);
  assign v6_nxt = load6 || (v6_r && !rdy7);
  assign v7_nxt = load7 || (v7_r && !rdy8);
  assign v8_nxt = load8 || (v8_r && !out_ready);

  // Signed product, so a losing trade extends with its sign.
  always_comb begin
    profit_nxt = '0;
    if (d.close) profit_nxt = $signed(d.diff) * $signed({1'b0, size});
  end

  // Saturate when the sum does not fit the PnL width.
  always_comb begin
    pnl_sum = mac_pkg::ADD_W'(pnl_r) + mac_pkg::ADD_W'(profit5_r);
    pnl_hi  = pnl_sum[mac_pkg::ADD_W-1:mac_pkg::PNL_W-1];
    if ((&pnl_hi) || !(|pnl_hi)) pnl_nxt = pnl_sum[mac_pkg::PNL_W-1:0];
    else if (pnl_sum[mac_pkg::ADD_W-1]) pnl_nxt = mac_pkg::PNL_MIN;
    else pnl_nxt = mac_pkg::PNL_MAX;

    trades_nxt = trades_r;
    wins_nxt   = wins_r;
    if (close5_r && trades_r != '1) trades_nxt = trades_r + 1'b1;
    if (close5_r && win5_r && wins_r != '1) wins_nxt = wins_r + 1'b1;
  end

  always_comb begin
    new_peak = pnl_r > peak_r;
    peak_nxt = new_peak ? pnl_r : peak_r;
    dd_raw   = mac_pkg::DDX_W'(peak_r) - mac_pkg::DDX_W'(pnl_r);
    if (new_peak) dd_nxt = '0;
    else if (dd_raw[mac_pkg::DDX_W-1:mac_pkg::DD_W] != '0) dd_nxt = '1;
    else dd_nxt = dd_raw[mac_pkg::DD_W-1:0];
    worst_nxt = (dd7_r > worst_r) ? dd7_r : worst_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r     <= 1'b0;
      v6_r     <= 1'b0;
      v7_r     <= 1'b0;
      v8_r     <= 1'b0;
      pnl_r    <= '0;
      trades_r <= '0;
      wins_r   <= '0;
      peak_r   <= '0;
      worst_r  <= '0;
    end else begin
      v5_r <= v5_nxt;
      v6_r <= v6_nxt;
      v7_r <= v7_nxt;
      v8_r <= v8_nxt;
      if (load6) begin
        pnl_r    <= pnl_nxt;
        trades_r <= trades_nxt;
        wins_r   <= wins_nxt;
      end
      if (load7) peak_r <= peak_nxt;
      if (load8) worst_r <= worst_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load5) begin
      act5_r    <= d.action;
      tp5_r     <= d.price;
      close5_r  <= d.close;
      win5_r    <= d.win;
      profit5_r <= profit_nxt;
    end
    if (load6) begin
      act6_r <= act5_r;
      tp6_r  <= tp5_r;
    end
    if (load7) begin
      act7_r    <= act6_r;
      tp7_r     <= tp6_r;
      pnl7_r    <= pnl_r;
      dd7_r     <= dd_nxt;
      trades7_r <= trades_r;
      wins7_r   <= wins_r;
    end
    if (load8) begin
      act8_r    <= act7_r;
      tp8_r     <= tp7_r;
      pnl8_r    <= pnl7_r;
      trades8_r <= trades7_r;
      wins8_r   <= wins7_r;
    end
  end

  assign out_valid  = v8_r;
  assign res.action = act8_r;
  assign res.tprice = mac_pkg::TP_W'(tp8_r);
  assign res.pnl    = pnl8_r;
  assign res.max_dd = worst_r;
  assign res.trades = trades8_r;
  assign res.wins   = wins8_r;

  a_wins_le_trades: assert property (@(posedge clk) disable iff (!rst_n)
    v8_r |-> trades8_r >= wins8_r)
    else $error("more wins than closed trades");

  a_dd_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> worst_r >= $past(worst_r))
    else $error("maximum drawdown decreased");

endmodule

### sv/moving_average_crossover_trader.sv
// Top level of the moving-average crossover trader.
// Holds the configuration registers and joins ring, signal and accounting stages.
// Depends on mac_pkg, mac_front, mac_signal and mac_acct.
//
// The block takes one price item per clock cycle unless a stalled output has
// filled the stages, and returns exactly one result item for each, in order.
// The item passes eight registered stages: one ring stage (price written and
// the two leaving prices read from the two-read ring memory), a window-sum
// stage, a stage that multiplies each sum by the other window length so the
// two averages compare exactly, a decision stage, a profit multiply, a
// saturating PnL stage, a peak and drawdown stage and the output register.
// Every stage has its own valid bit, so the block keeps accepting items while
// a result waits on a stalled output, until the stages in between are full.
// The running sums, the position, PnL, peak and drawdown are each updated by
// a single short step per item, which is what lets items follow back to back.
// Decisions start once the long window length plus one samples of the current
// series have arrived. An item with tlast set closes any open position at its
// own price and starts a new series; PnL, drawdown and trade counters carry
// on. Writing either window length register also starts a new series but
// leaves a position open.
// Configuration must only be written while no item is in flight. The ring
// memory needs no clearing after reset. Win rate is left to software as
// win_count / trade_count.
module moving_average_crossover_trader (
  input  logic                           clk,
  input  logic                           rst_n,
  // price[31:0]
  input  logic [mac_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           in_tlast,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // trade_price[31:0], pnl[79:32], max_drawdown[126:80], trade_count[158:127],
  // win_count[190:159], zero pad[191]
  output logic [mac_pkg::OUT_DATA_W-1:0] out_tdata,
  // action[2:0]
  output logic [mac_pkg::ACT_W-1:0]      out_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic                           cfg_wr_en,
  input  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mac_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [mac_pkg::WIN_W-1:0]  short_r, short_nxt, long_r, long_nxt;
  logic [mac_pkg::SIZE_W-1:0] size_r, size_nxt;
  logic                       series_clr;
  mac_pkg::win_t              win;

  logic          front_ready;
  logic          s1_valid, s1_ready;
  mac_pkg::s1_t  s1;
  logic          d_valid, d_ready;
  mac_pkg::dec_t d;
  mac_pkg::res_t res;

  // A window write restarts the series in the same cycle.
  always_comb begin
    short_nxt  = short_r;
    long_nxt   = long_r;
    size_nxt   = size_r;
    series_clr = 1'b0;
    if (cfg_wr_en) begin
      case (cfg_index)
        mac_pkg::CFG_SHORT: begin
          short_nxt  = cfg_wdata[mac_pkg::WIN_W-1:0];
          series_clr = 1'b1;
        end
        mac_pkg::CFG_LONG: begin
          long_nxt   = cfg_wdata[mac_pkg::WIN_W-1:0];
          series_clr = 1'b1;
        end
        mac_pkg::CFG_SIZE: begin
          size_nxt = cfg_wdata[mac_pkg::SIZE_W-1:0];
        end
        default: begin
          series_clr = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r <= mac_pkg::SHORT_RESET;
      long_r  <= mac_pkg::LONG_RESET;
      size_r  <= mac_pkg::SIZE_RESET;
    end else begin
      short_r <= short_nxt;
      long_r  <= long_nxt;
      size_r  <= size_nxt;
    end
  end

  assign win = mac_pkg::eff_windows(short_r, long_r);

  // No item is taken while reset is asserted.
  assign in_tready = rst_n && front_ready;

  mac_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .series_clr (series_clr),
    .win        (win),
    .in_valid   (in_tvalid && rst_n),
    .in_price   (in_tdata),
    .in_last    (in_tlast),
    .in_ready   (front_ready),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_ready   (s1_ready)
  );

  mac_signal u_signal (
    .clk        (clk),
    .rst_n      (rst_n),
    .series_clr (series_clr),
    .win        (win),
    .s1_valid   (s1_valid),
    .s1         (s1),
    .s1_ready   (s1_ready),
    .d_valid    (d_valid),
    .d          (d),
    .d_ready    (d_ready)
  );

  mac_acct u_acct (
    .clk       (clk),
    .rst_n     (rst_n),
    .size      (size_r),
    .d_valid   (d_valid),
    .d         (d),
    .d_ready   (d_ready),
    .out_valid (out_tvalid),
    .res       (res),
    .out_ready (out_tready)
  );

  assign out_tuser = res.action;
  assign out_tdata = mac_pkg::OUT_DATA_W'({res.wins, res.trades, res.max_dd,
                                          res.pnl, res.tprice});

endmodule

### tb/tb_moving_average_crossover_trader.sv
// Self-checking testbench for the moving-average crossover trader.
// Streams price items through the block, predicts every result in a ledger
// class and compares field by field. Depends on mac_pkg and the block itself.
module tb_moving_average_crossover_trader;

  // Sign of (short average - long average), kept from item to item so that a
  // change of sign can be seen as a crossover.
  typedef enum logic [1:0] {
    REL_LESS    = 2'd0,
    REL_EQUAL   = 2'd1,
    REL_GREATER = 2'd2
  } rel_t;

  localparam longint PNL_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint PNL_BOTTOM = -PNL_TOP - 1;
  localparam longint DD_TOP     = 64'sh0000_7FFF_FFFF_FFFF;

  // The ledger mirrors the trader: it keeps its own price ring, window sums,
  // position and profit bookkeeping, and queues the result that each accepted
  // price item must produce.
  class trade_ledger_t;
    logic [mac_pkg::WIN_W-1:0]  short_reg;
    logic [mac_pkg::WIN_W-1:0]  long_reg;
    logic [mac_pkg::SIZE_W-1:0] size_reg;
    logic [31:0]                ring [mac_pkg::MAX_WINDOW];
    int unsigned                write_slot;
    int unsigned                sample_count;
    logic [63:0]                short_sum;
    logic [63:0]                long_sum;
    rel_t                       prev_rel;
    bit                         holding;
    logic [31:0]                entry_level;
    longint                     pnl;
    longint                     peak;
    longint                     worst_dd;
    logic [31:0]                trades;
    logic [31:0]                wins;
    mac_pkg::res_t              expected_q[$];
    int                         errors;

    function new();
      short_reg   = mac_pkg::SHORT_RESET;
      long_reg    = mac_pkg::LONG_RESET;
      size_reg    = mac_pkg::SIZE_RESET;
      holding     = 1'b0;
      entry_level = '0;
      pnl         = 0;
      peak        = 0;
      worst_dd    = 0;
      trades      = '0;
      wins        = '0;
      errors      = 0;
      restart_series();
    endfunction

    function void restart_series();
      write_slot   = 0;
      sample_count = 0;
      short_sum    = '0;
      long_sum     = '0;
      prev_rel     = REL_EQUAL;
    endfunction

    // A window write starts a new series; a size write does not.
    function void write_register(logic [mac_pkg::CFG_IDX_W-1:0] idx,
                                 logic [mac_pkg::CFG_DATA_W-1:0] value);
      case (idx)
        mac_pkg::CFG_SHORT: begin
          short_reg = value[mac_pkg::WIN_W-1:0];
          restart_series();
        end
        mac_pkg::CFG_LONG: begin
          long_reg = value[mac_pkg::WIN_W-1:0];
          restart_series();
        end
        mac_pkg::CFG_SIZE: begin
          size_reg = value;
        end
        default: begin
        end
      endcase
    endfunction

    function void close_position(logic [31:0] p);
      longint profit;
      profit = (longint'(p) - longint'(entry_level)) * longint'(size_reg);
      pnl = pnl + profit;
      if (pnl > PNL_TOP) pnl = PNL_TOP;
      if (pnl < PNL_BOTTOM) pnl = PNL_BOTTOM;
      if (trades != '1) trades++;
      if (p > entry_level && wins != '1) wins++;
      holding = 1'b0;
    endfunction

    function void note_price(logic [31:0] p, bit end_flag);
      int unsigned   l;
      int unsigned   s;
      int unsigned   prior;
      rel_t          rel;
      mac_pkg::act_t act;
      logic [31:0]   tp;
      logic [63:0]   lhs;
      logic [63:0]   rhs;
      longint        dd_now;
      mac_pkg::res_t r;
      l = long_reg;
      if (l == 0) l = 1;
      if (l > mac_pkg::MAX_WINDOW) l = mac_pkg::MAX_WINDOW;
      s = short_reg;
      if (s == 0) s = 1;
      if (s > l) s = l;
      prior = sample_count;
      act = mac_pkg::ACT_NONE;
      tp = '0;
      rel = REL_EQUAL;

      // Drop the prices that fall out of each window, then add the new one.
      if (prior >= s)
        short_sum -= ring[(write_slot + mac_pkg::MAX_WINDOW - s) % mac_pkg::MAX_WINDOW];
      if (prior >= l)
        long_sum -= ring[(write_slot + mac_pkg::MAX_WINDOW - l) % mac_pkg::MAX_WINDOW];
      short_sum += p;
      long_sum += p;
      ring[write_slot] = p;
      write_slot = (write_slot + 1) % mac_pkg::MAX_WINDOW;
      if (sample_count < mac_pkg::MAX_WINDOW) sample_count++;

      if (prior + 1 >= l) begin
        lhs = short_sum * l;
        rhs = long_sum * s;
        rel = (lhs > rhs) ? REL_GREATER : ((lhs < rhs) ? REL_LESS : REL_EQUAL);
        if (prior >= l) begin
          if (!holding) begin
            if (prev_rel != REL_GREATER && rel == REL_GREATER) begin
              holding = 1'b1;
              entry_level = p;
              act = mac_pkg::ACT_BUY;
              tp = p;
            end
          end else if (prev_rel != REL_LESS && rel == REL_LESS) begin
            close_position(p);
            act = mac_pkg::ACT_SELL;
            tp = p;
          end
        end
        prev_rel = rel;
      end

      if (end_flag) begin
        if (holding) begin
          close_position(p);
          act = (act == mac_pkg::ACT_BUY) ? mac_pkg::ACT_BUY_FORCE : mac_pkg::ACT_FORCE;
          tp = p;
        end
        restart_series();
      end

      if (pnl > peak) peak = pnl;
      dd_now = peak - pnl;
      if (dd_now > DD_TOP) dd_now = DD_TOP;
      if (dd_now > worst_dd) worst_dd = dd_now;

      r.action = act;
      r.tprice = tp;
      r.pnl    = pnl[mac_pkg::PNL_W-1:0];
      r.max_dd = worst_dd[mac_pkg::DD_W-1:0];
      r.trades = trades;
      r.wins   = wins;
      expected_q = {expected_q, r};
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t %s mismatch: expected %h actual %h", $time, what, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [mac_pkg::ACT_W-1:0] act,
                               logic [mac_pkg::OUT_DATA_W-1:0] data);
      mac_pkg::res_t want;
      if (expected_q.size() == 0) begin
        $display("%0t result with nothing expected: expected none actual %h/%h",
                 $time, act, data);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("action", 64'(want.action), 64'(act));
      compare_field("trade_price", 64'(want.tprice), 64'(data[31:0]));
      compare_field("pnl", 64'(want.pnl[mac_pkg::PNL_W-1:0]), 64'(data[79:32]));
      compare_field("max_drawdown", 64'(want.max_dd), 64'(data[126:80]));
      compare_field("trade_count", 64'(want.trades), 64'(data[158:127]));
      compare_field("win_count", 64'(want.wins), 64'(data[190:159]));
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst_n;
  logic [mac_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                           in_tlast;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [mac_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [mac_pkg::ACT_W-1:0]      out_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic                           cfg_wr_en;
  logic [mac_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [mac_pkg::CFG_DATA_W-1:0] cfg_wdata;

  trade_ledger_t ledger = new();

  // Percentages of cycles in which the sender idles and the receiver stalls.
  int send_idle_pct = 0;
  int stall_pct     = 0;
  // The stimulus asks for a long receiver hold-off by bumping hold_requests;
  // the receiver process counts the stretch itself.
  int hold_requests = 0;

  moving_average_crossover_trader DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #(12 * 400000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // Receiver: checks every accepted result item, then picks the next ready
  // level. A pending hold-off request lowers ready for a long stretch so
  // that the pipeline fills and the block drops in_tready.
  initial begin : receiver
    int holds_served;
    int hold_left;
    holds_served = 0;
    hold_left = 0;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) ledger.check_result(out_tuser, out_tdata);
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = 150;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= !(stall_pct != 0 && $urandom_range(99) < stall_pct);
      end
    end
  end

  // Offers one price item, idling first at the current rate, and records it in
  // the ledger at the edge where it is accepted. Valid stays high afterwards
  // so that back-to-back items need no gap.
  task automatic offer_price(input logic [31:0] p, input bit end_flag);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    in_tlast  <= end_flag;
    do @(posedge clk); while (!in_tready);
    ledger.note_price(p, end_flag);
  endtask

  // Every item yields exactly one result, so the block is idle once the
  // ledger has nothing left to wait for.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (ledger.expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic put_register(input logic [mac_pkg::CFG_IDX_W-1:0] idx,
                              input logic [mac_pkg::CFG_DATA_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    ledger.write_register(idx, value);
  endtask

  task automatic load_settings(input logic [mac_pkg::CFG_DATA_W-1:0] sw,
                               input logic [mac_pkg::CFG_DATA_W-1:0] lw,
                               input logic [mac_pkg::CFG_DATA_W-1:0] sz);
    put_register(mac_pkg::CFG_SHORT, sw);
    put_register(mac_pkg::CFG_LONG, lw);
    put_register(mac_pkg::CFG_SIZE, sz);
    cfg_wr_en <= 1'b0;
  endtask

  // Directed part with one-sample against two-sample averages, where the
  // relation simply follows whether the price rose or fell. It covers both
  // saturation limits of the PnL and the drawdown limit, a buy and a forced
  // sell on the same item, a plain forced sell, a zero position size and a
  // window write that leaves a position open.
  task automatic directed_trades();
    load_settings(16'd1, 16'd2, 16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 0;
    offer_price(32'd5, 1'b0);
    offer_price(32'd5, 1'b0);
    offer_price(32'd5, 1'b0);
    offer_price(32'd6, 1'b0);           // buy
    offer_price(32'hFFFF_FFFF, 1'b0);
    offer_price(32'hFFFF_FFFE, 1'b0);   // sell far above entry: PnL at its top
    offer_price(32'd0, 1'b0);
    offer_price(32'd0, 1'b0);
    offer_price(32'hFFFF_FFFF, 1'b0);   // buy at the highest price
    offer_price(32'd0, 1'b1);           // sell at zero: drawdown saturates
    offer_price(32'd0, 1'b0);
    offer_price(32'd0, 1'b0);
    offer_price(32'hFFFF_FFFF, 1'b0);   // buy at the highest price again
    offer_price(32'd0, 1'b1);           // second large loss: PnL at its bottom
    offer_price(32'd3, 1'b0);
    offer_price(32'd3, 1'b0);
    offer_price(32'd9, 1'b1);           // buy and forced sell on one item
    offer_price(32'd3, 1'b0);
    offer_price(32'd3, 1'b0);
    offer_price(32'd9, 1'b0);
    offer_price(32'd10, 1'b0);
    offer_price(32'd11, 1'b1);          // forced sell of an open position
    drain();
    put_register(mac_pkg::CFG_SIZE, 16'd0);
    cfg_wr_en <= 1'b0;
    offer_price(32'd3, 1'b0);
    offer_price(32'd3, 1'b0);
    offer_price(32'd9, 1'b0);
    offer_price(32'd2, 1'b1);           // losing trade counted, no profit change
    offer_price(32'd3, 1'b0);
    offer_price(32'd3, 1'b0);
    offer_price(32'd9, 1'b0);           // buy, position stays open over the write
    drain();
    put_register(mac_pkg::CFG_SHORT, 16'd1);
    cfg_wr_en <= 1'b0;
    offer_price(32'd9, 1'b1);           // forced sell at the entry price: no win
    drain();
  endtask

  // Random price walk: trend segments with noise, so that the averages cross
  // often, plus occasional jumps and extreme prices. Series lengths are random
  // up to longest_series and end with tlast.
  task automatic run_random(input bit load_regs,
                            input logic [mac_pkg::CFG_DATA_W-1:0] sw,
                            input logic [mac_pkg::CFG_DATA_W-1:0] lw,
                            input logic [mac_pkg::CFG_DATA_W-1:0] sz,
                            input int n, input int idle_pct, input int stall,
                            input int longest_series, input bit with_hold);
    logic [31:0] level;
    int          trend;
    int          left;
    int          pick;
    bit          end_flag;
    if (load_regs) load_settings(sw, lw, sz);
    send_idle_pct = idle_pct;
    stall_pct = stall;
    level = $urandom;
    trend = 0;
    left = $urandom_range(longest_series, 1);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(11) == 0) trend = int'($urandom_range(80)) - 40;
      level = level + trend + int'($urandom_range(40)) - 20;
      pick = $urandom_range(99);
      if (pick == 0) level = '0;
      else if (pick == 1) level = '1;
      else if (pick < 5) level = $urandom;
      end_flag = (left == 1);
      left--;
      if (left == 0) left = $urandom_range(longest_series, 1);
      if (with_hold && k == n / 2) hold_requests++;
      offer_price(level, end_flag);
    end
    drain();
  endtask

  initial begin : stimulus
    int idle_by_phase [4];
    int stall_by_phase [4];
    logic [mac_pkg::CFG_DATA_W-1:0] sw;
    logic [mac_pkg::CFG_DATA_W-1:0] lw;
    idle_by_phase  = '{0, 76, 0, 34};
    stall_by_phase = '{0, 0, 76, 34};
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_wr_en <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset values of the registers first, with no write at all.
    run_random(1'b0, '0, '0, '0, 120, 0, 0, 90, 1'b0);
    directed_trades();

    // Small random windows, where crossovers are frequent, under each idling
    // mix. Short may exceed long, which exercises the clamp. The first block
    // carries the long receiver hold-off.
    for (int phase = 0; phase < 4; phase++) begin
      for (int blk = 0; blk < 2; blk++) begin
        sw = mac_pkg::CFG_DATA_W'($urandom_range(8, 1));
        lw = mac_pkg::CFG_DATA_W'($urandom_range(24, 1));
        run_random(1'b1, sw, lw, mac_pkg::CFG_DATA_W'($urandom_range(65535, 1)), 100,
                   idle_by_phase[phase], stall_by_phase[phase], 60,
                   phase == 0 && blk == 0);
      end
    end

    // Window extremes: full ring depth for both averages, the widest spread,
    // zero and out-of-range register values.
    run_random(1'b1, 16'd256, 16'd256, 16'd1, 320, 0, 0, 400, 1'b0);
    run_random(1'b1, 16'd1, 16'd256, 16'hFFFF, 280, 34, 34, 400, 1'b0);
    run_random(1'b1, 16'd0, 16'd511, 16'd777, 40, 0, 76, 400, 1'b0);
    run_random(1'b1, 16'd511, 16'd0, 16'd12, 30, 76, 0, 10, 1'b0);

    // Let any stray result show up before the verdict.
    repeat (20) @(posedge clk);
    if (ledger.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

### sim.f
sv/mac_pkg.sv
sv/mac_front.sv
sv/mac_signal.sv
sv/mac_acct.sv
sv/moving_average_crossover_trader.sv
tb/tb_moving_average_crossover_trader.sv
